>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/b58_pkg.sv
// ----------------------------------------------------------------------------
// Base-58 encoder package
// Widths, the divide-by-58 reciprocal, the divider result type and the
// alphabet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b58_pkg;

  localparam int unsigned UID_W      = 32;
  localparam int unsigned DIG_W      = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned QUO_W      = 27;
  localparam int unsigned REM_W      = 7;
  localparam int unsigned MAX_DIGITS = 6;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned RADIX      = 58;
  localparam int unsigned PROD_W     = UID_W + QUO_W;

  // floor(2^32 / 58); the estimate it gives is low by at most one.
  localparam logic [QUO_W-1:0] RECIP = 27'd74051160;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [DIG_W-1:0] rem;
  } b58_divres_t;

  // Map one digit to its ASCII character: 1-9, a-z without l,
  // A-Z without I and O. Digits outside the alphabet map to '1'.
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIG_W-1:0] d);
    priority if (d < 6'd9) begin
      return CHAR_W'(d) + 7'd49;
    end else if (d < 6'd20) begin
      return CHAR_W'(d) + 7'd88;
    end else if (d < 6'd34) begin
      return CHAR_W'(d) + 7'd89;
    end else if (d < 6'd42) begin
      return CHAR_W'(d) + 7'd31;
    end else if (d < 6'd47) begin
      return CHAR_W'(d) + 7'd32;
    end else if (d < 6'd58) begin
      return CHAR_W'(d) + 7'd33;
    end else begin
      return 7'd49;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/base58_uid_encoder.sv
// ----------------------------------------------------------------------------
// Base-58 identifier encoder
// Converts a 32-bit identifier into one to six base-58 ASCII characters.
// ----------------------------------------------------------------------------
// Usage: drive in_uid_value and raise start while busy is low; the item is
// taken at that clock edge. The block then divides the value by 58 over and
// over in one shared divider, storing each remainder in a six-entry digit
// buffer, and finally plays the characters out most significant first.
// Each character appears on out_char_code for exactly one cycle with
// out_valid high; out_last_char marks the least significant one. The
// receiver cannot stall the result channel, so characters go out one per
// cycle with no gaps.
// Steps for an identifier with n characters: every division is a reciprocal
// multiply, then a correction, and n-1 of them are needed; one more
// multiply-state step stores the top digit. The characters then go out
// from the digit buffer, and busy stays high until the last one has been
// read, so the block takes no new item before it is through with the
// last one. The shared divider and the play-out set the item rate.
// Reset (synchronous, rst_n low) returns the sequencer to idle and clears
// the strobe; no state survives from one identifier to the next.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module base58_uid_encoder
  import b58_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [UID_W-1:0]  in_uid_value,
  output      logic              out_valid,
  output      logic [CHAR_W-1:0] out_char_code,
  output      logic              out_last_char
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r,   state_nxt;
  logic [UID_W-1:0]  val_r,     val_nxt;
  logic [CNT_W-1:0]  n_r,       n_nxt;
  logic [CNT_W-1:0]  idx_r,     idx_nxt;
  logic              valid_r,   valid_nxt;
  logic [CHAR_W-1:0] char_r,    char_nxt;
  logic              last_r,    last_nxt;

  // Digit buffer, filled least significant first.
  logic [DIG_W-1:0]  dig_r [MAX_DIGITS];
  logic              dig_we;
  logic [DIG_W-1:0]  dig_wdata;

  b58_divres_t       div_res;
  logic              div_load;
  logic              rem_ok;

  assign div_load = (state_r == ST_MUL);
  assign rem_ok   = (div_res.rem < DIG_W'(RADIX));

  b58_divmod u_divmod (
    .clk      (clk),
    .load     (div_load),
    .dividend (val_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    dig_we    = 1'b0;
    dig_wdata = div_res.rem;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt   = in_uid_value;
          n_nxt     = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Once the value is below the radix it is the top digit itself.
        // The divider is loaded anyway; its result is ignored then.
        if (val_r < UID_W'(RADIX)) begin
          dig_we    = 1'b1;
          dig_wdata = val_r[DIG_W-1:0];
          idx_nxt   = n_r;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        dig_we    = 1'b1;
        val_nxt   = UID_W'(div_res.quo);
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = ST_MUL;
      end
      ST_EMIT: begin
        valid_nxt = 1'b1;
        char_nxt  = b58_char(dig_r[idx_r]);
        last_nxt  = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      n_r     <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (dig_we) begin
      dig_r[n_r] <= dig_wdata;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  // An accepted item always starts a division round.
  `ASSERT_NEXT(a_start_mul, clk, rst_n, start && !busy, state_r == ST_MUL, "item not started")

  // The corrected remainder must be a valid digit.
  `ASSERT_IMPLIES(a_rem_ok, clk, rst_n, state_r == ST_FIX, rem_ok, "remainder out of range")

  // A 32-bit value never needs more than six digits.
  `ASSERT_IMPLIES(a_ndig, clk, rst_n, state_r == ST_MUL, n_r < CNT_W'(MAX_DIGITS), "overrun")

  // Every play-out cycle produces a strobe in the next cycle.
  `ASSERT_NEXT(a_emit_strobe, clk, rst_n, state_r == ST_EMIT, out_valid, "strobe missing")

endmodule

`default_nettype wire

>>> sv/b58_divmod.sv
// ----------------------------------------------------------------------------
// Divide-by-58 unit
// Reciprocal multiply into a register, then one subtract-and-correct step.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_divmod
  import b58_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [UID_W-1:0]  dividend,
  output b58_divres_t            res
);

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  qest_r;
  logic [UID_W-1:0]  dividend_r;
  logic [UID_W-1:0]  qtimes;
  logic [UID_W-1:0]  diff;
  logic [REM_W-1:0]  rraw;

  assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      qest_r     <= prod[PROD_W-1:UID_W];
      dividend_r <= dividend;
    end
  end

  // 58 = 32 + 16 + 8 + 2
  assign qtimes = (UID_W'(qest_r) << 5) + (UID_W'(qest_r) << 4)
                + (UID_W'(qest_r) << 3) + (UID_W'(qest_r) << 1);
  assign diff   = dividend_r - qtimes;
  assign rraw   = diff[REM_W-1:0];

  always_comb begin
    if (rraw >= REM_W'(RADIX)) begin
      res.quo = qest_r + QUO_W'(1);
      res.rem = DIG_W'(rraw - REM_W'(RADIX));
    end else begin
      res.quo = qest_r;
      res.rem = rraw[DIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> bench/base58_uid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base-58 encoder checker
// Watches the item and character channels of the encoder, works out the
// characters each accepted identifier must produce and compares them in order.
// ----------------------------------------------------------------------------

module base58_uid_checker
  import b58_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [UID_W-1:0]  uid_value,
  input  wire logic              out_valid,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              last_char,
  output int unsigned            mismatches,
  output int unsigned            chars_pending,
  output int unsigned            chars_checked
);

  localparam int unsigned PRINT_CAP = 60;

  // Alphabet, first symbol in the top byte.
  localparam logic [8*58-1:0] B58_SYMBOLS =
    "123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

  typedef struct {
    logic [UID_W-1:0]  uid;
    logic [CHAR_W-1:0] code;
    logic              last;
  } b58_char_exp_t;

  b58_char_exp_t pending_chars[$];
  int unsigned   err_cnt = 0;
  int unsigned   seen_cnt = 0;

  task automatic report_mismatch(input string what);
    if (err_cnt < PRINT_CAP) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
    err_cnt++;
  endtask

  // Split the identifier into base-58 digits, least significant first, and
  // queue their characters most significant first.
  function automatic void encode_uid(input logic [UID_W-1:0] uid);
    logic [UID_W-1:0] rest;
    logic [DIG_W-1:0] digit_buf [MAX_DIGITS];
    int               n;
    b58_char_exp_t    e;
    rest = uid;
    n    = 0;
    while (rest >= RADIX && n < MAX_DIGITS - 1) begin
      digit_buf[n] = DIG_W'(rest % RADIX);
      rest         = rest / RADIX;
      n++;
    end
    digit_buf[n] = DIG_W'(rest % RADIX);
    n++;
    for (int k = n - 1; k >= 0; k--) begin
      e.uid  = uid;
      e.code = B58_SYMBOLS[8*(57 - digit_buf[k]) +: CHAR_W];
      e.last = (k == 0);
      pending_chars.push_back(e);
    end
  endfunction

  // Characters are compared before a newly accepted identifier is queued,
  // so a stray character can never match the identifier taken on that edge.
  always @(posedge clk) begin : watch
    b58_char_exp_t head;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", char_code));
        end else begin
          head = pending_chars.pop_front();
          seen_cnt++;
          if (char_code !== head.code) begin
            report_mismatch($sformatf("uid %0d: char_code 0x%02h, expected 0x%02h",
                                      head.uid, char_code, head.code));
          end
          if (last_char !== head.last) begin
            report_mismatch($sformatf("uid %0d: last_char %b, expected %b",
                                      head.uid, last_char, head.last));
          end
        end
      end
      if (start && !busy) begin
        encode_uid(uid_value);
      end
    end
    mismatches    <= err_cnt;
    chars_pending <= pending_chars.size();
    chars_checked <= seen_cnt;
  end

endmodule

>>> bench/tb_base58_uid_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base-58 identifier encoder testbench
// Feeds directed boundary identifiers and then random ones of every length
// into the encoder, with random pauses between items, while a checker module
// predicts and compares every character that comes out.
// ----------------------------------------------------------------------------

module tb_base58_uid_encoder
  import b58_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 195;
  // A correct run of all 220 items and their pauses stays far below this.
  localparam int unsigned CYCLE_LIMIT  = 60000;
  // Wait after the last expected character, to catch any stray ones.
  localparam int unsigned TAIL_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [UID_W-1:0]  in_uid_value;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char_code;
  logic              out_last_char;

  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned chars_checked;
  int unsigned cycle_cnt = 0;
  int unsigned uids_sent = 0;
  int unsigned directed_cnt = 0;

  always #5 clk = ~clk;

  base58_uid_encoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_uid_value  (in_uid_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  base58_uid_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .uid_value     (in_uid_value),
    .out_valid     (out_valid),
    .char_code     (out_char_code),
    .last_char     (out_last_char),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  // Hard stop in case the encoder hangs or stops producing characters.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_cnt, chars_pending);
      $display("tb_base58_uid_encoder: errors");
      $finish;
    end
  end

  // Offers one identifier and returns at the edge that accepted it. Start is
  // left high, so back-to-back items keep it asserted; a pause lowers it in
  // the step of the previous acceptance and raises it in a later one. Random
  // pause lengths land the next start on every phase of the divider loop,
  // from the very first cycle of busy to well after idle.
  task automatic send_uid(input logic [UID_W-1:0] value, input bit allow_pause);
    int unsigned pause;
    if (allow_pause && $urandom_range(99) < 7) begin
      pause = $urandom_range(18, 1);
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    start        <= 1'b1;
    in_uid_value <= value;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    uids_sent++;
  endtask

  // A value with exactly the requested number of base-58 digits. Six digits
  // run up to the top of the 32-bit range.
  function automatic logic [UID_W-1:0] uid_with_digits(input int unsigned ndig);
    longint unsigned lo;
    longint unsigned hi;
    lo = 0;
    hi = 58;
    for (int unsigned i = 1; i < ndig; i++) begin
      lo = hi;
      hi = hi * 58;
    end
    if (hi > 64'hFFFF_FFFF + 1) begin
      hi = 64'hFFFF_FFFF + 1;
    end
    return $urandom_range(32'(hi - 1), 32'(lo));
  endfunction

  // Identifiers at the edges of every digit count, the extremes of the input
  // field, alternating bit patterns and single digits at the seams of the
  // alphabet (the jumps past 9, l, I and O).
  logic [UID_W-1:0] directed_uids [25] = '{
    32'd0, 32'd1, 32'd8, 32'd9, 32'd19, 32'd20, 32'd33, 32'd34, 32'd41,
    32'd42, 32'd46, 32'd47, 32'd57, 32'd58, 32'd3363, 32'd3364,
    32'd195111, 32'd195112, 32'd11316495, 32'd11316496,
    32'd656356767, 32'd656356768, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFF
  };

  initial begin
    bit quiet;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_uid_value = '0;

    // Reset is held from the start and never asserted again.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_uids[i]) begin
      send_uid(directed_uids[i], 1'b1);
    end
    directed_cnt = uids_sent;

    // Random part: most items have a digit count chosen at random so short
    // identifiers are as common as long ones; some are fully random 32-bit
    // words so every input bit takes both values. Items 60 to 139 run with
    // no pauses, keeping the encoder saturated.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 60 && i < 140);
      if ($urandom_range(99) < 15) begin
        send_uid($urandom, !quiet);
      end else begin
        send_uid(uid_with_digits($urandom_range(6, 1)), !quiet);
      end
    end
    start <= 1'b0;

    // Let the checker's registered counts take in the last accepted item, then
    // wait for every queued character and a little longer for stray ones.
    @(posedge clk);
    while (chars_pending != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d identifiers (%0d directed boundary values, the rest random",
             uids_sent, directed_cnt);
    $display("across one to six digits) and compared %0d output characters.",
             chars_checked);
    if (mismatches == 0) begin
      $display("tb_base58_uid_encoder: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_base58_uid_encoder: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/b58_pkg.sv
sv/b58_divmod.sv
sv/base58_uid_encoder.sv
bench/base58_uid_checker.sv
bench/tb_base58_uid_encoder.sv
